>>> rtl/core/plle_pkg.sv
package plle_pkg;

    localparam int PLLE_CAPACITY = 64;

    localparam int REQ_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int SIZE_W = 7;
    localparam int STAT_W = 2;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_AT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_VAL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } plle_req_t;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [SIZE_W-1:0] list_size;
        logic [STAT_W-1:0] status;
    } plle_res_t;

    typedef struct packed {
        logic equal;
        logic below;
        logic next_below;
        logic match;
    } plle_flags_t;

endpackage

>>> rtl/core/plle_step.sv
module plle_step
    import plle_pkg::*;
#(
    parameter int CAPACITY = PLLE_CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  logic [CW-1:0]    idx,
    input  logic [CW-1:0]    limit,
    input  logic             down,
    input  logic [VAL_W-1:0] rdata,
    input  logic [VAL_W-1:0] value,
    output logic [CW-1:0]    next_idx,
    output plle_flags_t      flags
);

    assign next_idx = down ? CW'(idx - 1'b1) : CW'(idx + 1'b1);

    assign flags.equal      = (idx == limit);
    assign flags.below      = (idx < limit);
    assign flags.next_below = (next_idx < limit);
    assign flags.match      = (rdata == value);

endmodule

>>> rtl/core/plle_ctrl.sv
module plle_ctrl
    import plle_pkg::*;
#(
    parameter int CAPACITY = PLLE_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  plle_req_t req,
    output logic      idle,
    output logic      res_valid,
    input  logic      res_take,
    output plle_res_t res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_INS      = 9'b000000010,
        ST_INS_WR   = 9'b000000100,
        ST_SCAN     = 9'b000001000,
        ST_SCAN_CMP = 9'b000010000,
        ST_CLOSE    = 9'b000100000,
        ST_CLOSE_WR = 9'b001000000,
        ST_RD_WAIT  = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [VAL_W-1:0]   rd_reg, rd_next;

    logic [VAL_W-1:0]   mem [CAPACITY];
    logic [VAL_W-1:0]   rdata_reg;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [VAL_W-1:0]   wdata;
    logic               re;
    logic [AW-1:0]      raddr;

    logic [PW-1:0]      pos_ext;
    logic [PW-1:0]      count_ext;
    logic               down;
    logic [CW-1:0]      limit;
    logic [CW-1:0]      next_idx;
    plle_flags_t        flags;

    assign pos_ext   = PW'(req.position);
    assign count_ext = PW'(count_reg);
    assign down      = (state_reg == ST_INS) || (state_reg == ST_INS_WR);
    assign limit     = (state_reg == ST_INS) ? pos_reg : count_reg;

    plle_step #(
        .CAPACITY (CAPACITY)
    ) u_step (
        .idx      (idx_reg),
        .limit    (limit),
        .down     (down),
        .rdata    (rdata_reg),
        .value    (value_reg),
        .next_idx (next_idx),
        .flags    (flags)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        value_next  = value_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        we          = 1'b0;
        waddr       = idx_reg[AW-1:0];
        wdata       = rdata_reg;
        re          = 1'b0;
        raddr       = idx_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = STAT_OK;
                    rd_next     = '0;
                    value_next  = req.value;
                    state_next  = ST_DONE;
                    case (req.req_type)
                        REQ_APPEND:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = count_reg[AW-1:0];
                                wdata      = req.value;
                                count_next = CW'(count_reg + 1'b1);
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (pos_ext > count_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                pos_next   = pos_ext[CW-1:0];
                                state_next = ST_INS;
                            end
                        end
                        REQ_DEL_AT:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                idx_next   = pos_ext[CW-1:0];
                                state_next = ST_CLOSE;
                            end
                        end
                        REQ_DEL_VAL:
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                        REQ_READ:
                        begin
                            if (pos_ext >= count_ext)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                re         = 1'b1;
                                raddr      = pos_ext[AW-1:0];
                                state_next = ST_RD_WAIT;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INS:
            begin
                if (flags.equal)
                begin
                    we         = 1'b1;
                    wdata      = value_reg;
                    count_next = CW'(count_reg + 1'b1);
                    state_next = ST_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = next_idx[AW-1:0];
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR:
            begin
                we         = 1'b1;
                idx_next   = next_idx;
                state_next = ST_INS;
            end
            ST_SCAN:
            begin
                if (!flags.below)
                begin
                    status_next = STAT_NOTFOUND;
                    state_next  = ST_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (flags.match)
                begin
                    state_next = ST_CLOSE;
                end
                else
                begin
                    idx_next   = next_idx;
                    state_next = ST_SCAN;
                end
            end
            ST_CLOSE:
            begin
                if (!flags.next_below)
                begin
                    count_next = CW'(count_reg - 1'b1);
                    state_next = ST_DONE;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = next_idx[AW-1:0];
                    state_next = ST_CLOSE_WR;
                end
            end
            ST_CLOSE_WR:
            begin
                we         = 1'b1;
                idx_next   = next_idx;
                state_next = ST_CLOSE;
            end
            ST_RD_WAIT:
            begin
                rd_next    = rdata_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign idle           = (state_reg == ST_IDLE);
    assign res_valid      = (state_reg == ST_DONE);
    assign res.read_value = rd_reg;
    assign res.list_size  = count_ext[SIZE_W-1:0];
    assign res.status     = status_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list size exceeds capacity");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (CW'(waddr) <= count_reg))
        else $error("write beyond the end of the list");

    a_close_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE) |-> (idx_reg < count_reg))
        else $error("gap close index outside the list");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS) && flags.equal
        |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("insert did not grow the list");
`endif

endmodule

>>> rtl/core/positional_list_engine.sv
// Channel   Direction  tdata (low bit up)                  tuser
// s_axis    in         position[6:0], value[38:7], pad    req_type[2:0]
// m_axis    out        read_value[31:0], list_size[38:32]  status[1:0]
//
// Append, clear and rejected requests go from idle straight to the result;
// a read first waits for the registered memory read. Insert and delete move
// one entry at a time (one read, one write of the list memory per entry).
// Delete by value scans the entries, one read and compare each, before the move.
// Reset empties the list at once; the memory itself is not cleared.
// A new request is taken while the previous result still waits on m_axis.
module positional_list_engine
    import plle_pkg::*;
#(
    parameter int CAPACITY = PLLE_CAPACITY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // position[6:0], value[38:7], zero pad [39]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[2:0]
    input  logic [REQ_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_value[31:0], list_size[38:32], zero pad [39]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [STAT_W-1:0]     m_axis_tuser
);

    plle_req_t              req;
    plle_res_t              res;
    logic                   idle;
    logic                   res_valid;
    logic                   res_take;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [STAT_W-1:0]      out_user_reg;

    assign req.req_type = s_axis_tuser;
    assign req.position = s_axis_tdata[POS_W-1:0];
    assign req.value    = s_axis_tdata[POS_W+VAL_W-1:POS_W];

    assign s_axis_tready = idle;
    assign res_take      = res_valid && (!out_valid_reg || m_axis_tready);

    plle_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req       (req),
        .idle      (idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= {1'b0, res.list_size, res.read_value};
            out_user_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

>>> sim/plle_list_checker.sv
module plle_list_checker
    import plle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [REQ_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [STAT_W-1:0]     m_tuser,
    output int                    failures,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [VAL_W-1:0] list_mem [PLLE_CAPACITY];
    int               list_len;
    plle_res_t        expected_outcomes [$];
    plle_req_t        seen_req;
    plle_res_t        got;
    plle_res_t        want;

    function automatic void remove_entry(input int at);
        int i;
        for (i = at; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i + 1];
        list_len--;
    endfunction

    function automatic plle_res_t apply_request(input plle_req_t rq);
        plle_res_t res;
        int        i;
        int        hit;
        res        = '0;
        res.status = STAT_OK;
        hit        = -1;
        case (rq.req_type)
            REQ_APPEND:
            begin
                if (list_len >= PLLE_CAPACITY)
                    res.status = STAT_FULL;
                else
                begin
                    list_mem[list_len] = rq.value;
                    list_len++;
                end
            end
            REQ_INSERT:
            begin
                if (int'(rq.position) > list_len)
                    res.status = STAT_RANGE;
                else if (list_len >= PLLE_CAPACITY)
                    res.status = STAT_FULL;
                else
                begin
                    for (i = list_len; i > int'(rq.position); i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[rq.position] = rq.value;
                    list_len++;
                end
            end
            REQ_DEL_AT:
            begin
                if (int'(rq.position) >= list_len)
                    res.status = STAT_RANGE;
                else
                    remove_entry(int'(rq.position));
            end
            REQ_DEL_VAL:
            begin
                for (i = 0; i < list_len && hit < 0; i++)
                    if (list_mem[i] == rq.value)
                        hit = i;
                if (hit < 0)
                    res.status = STAT_NOTFOUND;
                else
                    remove_entry(hit);
            end
            REQ_READ:
            begin
                if (int'(rq.position) >= list_len)
                    res.status = STAT_RANGE;
                else
                    res.read_value = list_mem[rq.position];
            end
            REQ_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        res.list_size = SIZE_W'(list_len);
        return res;
    endfunction

    // Results are always for requests taken at earlier edges, so the order of
    // the two handshakes within one edge does not matter.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len = 0;
            expected_outcomes.delete();
            pending  = 0;
            failures = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.read_value = m_tdata[VAL_W-1:0];
                got.list_size  = m_tdata[VAL_W +: SIZE_W];
                got.status     = m_tuser;
                if (expected_outcomes.size() == 0)
                begin
                    $error("unexpected result: read_value %0d, list_size %0d, status %0d",
                           $signed(got.read_value), got.list_size, got.status);
                    failures++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(want.read_value), $signed(got.read_value));
                        failures++;
                    end
                    if (got.list_size !== want.list_size)
                    begin
                        $error("list_size: expected %0d, got %0d",
                               want.list_size, got.list_size);
                        failures++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                seen_req.req_type = s_tuser;
                seen_req.position = s_tdata[POS_W-1:0];
                seen_req.value    = s_tdata[POS_W +: VAL_W];
                expected_outcomes.push_back(apply_request(seen_req));
            end
            pending = expected_outcomes.size();
        end
    end

endmodule

>>> sim/positional_list_engine_tb.sv
module positional_list_engine_tb;
    import plle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_AFTER  = 250;
    localparam int HOLD_CYCLES = 500;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [REQ_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]     m_axis_tuser;

    int failures;
    int pending;
    int cycles = 0;
    int sent = 0;
    int taken = 0;

    always #6 clk = ~clk;

    positional_list_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    plle_list_checker list_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .failures (failures),
        .pending  (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        int gap;
        gap = ((sent / 110) % 3 != 1) ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, val, pos};
        do @(posedge clk); while (!s_axis_tready);
        sent++;
        @(negedge clk);
    endtask

    // Growing phases favor appends and inserts so that the list reaches its
    // capacity; shrinking phases favor deletions.
    task automatic send_random(input bit grow);
        int               pick;
        int               r;
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        pick = $urandom_range(0, 99);
        if (pick == 99)
            kind = REQ_CLEAR;
        else if (pick == 98)
            kind = $urandom_range(0, 1) ? REQ_SPARE_LO : REQ_SPARE_HI;
        else if (grow)
            kind = pick < 30 ? REQ_APPEND : pick < 60 ? REQ_INSERT :
                   pick < 70 ? REQ_DEL_AT : pick < 80 ? REQ_DEL_VAL : REQ_READ;
        else
            kind = pick < 10 ? REQ_APPEND : pick < 20 ? REQ_INSERT :
                   pick < 48 ? REQ_DEL_AT : pick < 72 ? REQ_DEL_VAL : REQ_READ;
        r = $urandom_range(0, 9);
        if (r < 4)
            pos = POS_W'($urandom_range(0, 15));
        else if (r < 8)
            pos = POS_W'($urandom_range(0, 66));
        else
            pos = POS_W'($urandom());
        // A small pool of values makes duplicates and successful searches common.
        if ($urandom_range(0, 9) < 6)
            val = VAL_W'($urandom_range(0, 11)) - VAL_W'(6);
        else
            val = $urandom();
        send_request(kind, pos, val);
    endtask

    initial
    begin
        int gap;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (taken == HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = ((taken / 90) % 3 != 2) ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(REQ_READ, 7'd0, 32'd0);
        send_request(REQ_DEL_AT, 7'd0, 32'd0);
        send_request(REQ_DEL_VAL, 7'd0, 32'd7);
        send_request(REQ_INSERT, 7'd1, 32'd1);
        send_request(REQ_CLEAR, 7'd0, 32'd0);
        send_request(REQ_INSERT, 7'd0, 32'h7FFF_FFFF);
        send_request(REQ_APPEND, 7'd0, 32'h8000_0000);
        send_request(REQ_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 7'd3, 32'd5);
        send_request(REQ_INSERT, 7'd1, 32'd5);
        send_request(REQ_APPEND, 7'd0, 32'd0);
        send_request(REQ_DEL_VAL, 7'd0, 32'd5);
        send_request(REQ_READ, 7'd3, 32'd0);
        send_request(REQ_READ, 7'd0, 32'd0);
        send_request(REQ_READ, 7'd5, 32'd0);
        send_request(REQ_READ, 7'd127, 32'd0);
        send_request(REQ_INSERT, 7'd127, 32'd0);
        send_request(REQ_DEL_AT, 7'd4, 32'd0);
        send_request(REQ_DEL_AT, 7'd0, 32'd0);
        send_request(REQ_DEL_VAL, 7'd0, 32'h8000_0000);
        send_request(REQ_SPARE_LO, 7'd127, 32'hFFFF_FFFF);
        send_request(REQ_SPARE_HI, 7'd0, 32'd0);
        send_request(REQ_READ, 7'd1, 32'd0);
        send_request(REQ_CLEAR, 7'd0, 32'd0);
        send_request(REQ_READ, 7'd0, 32'd0);

        repeat (66) send_request(REQ_APPEND, POS_W'($urandom()), $urandom());
        send_request(REQ_INSERT, 7'd0, $urandom());
        send_request(REQ_INSERT, 7'd64, $urandom());
        send_request(REQ_INSERT, 7'd65, $urandom());
        send_request(REQ_READ, 7'd63, 32'd0);
        send_request(REQ_READ, 7'd64, 32'd0);

        for (int phase = 0; phase < 12; phase++)
            repeat (155) send_random(phase % 2 == 0);

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (300) @(posedge clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
